[design/agwh_pkg.sv]
`default_nettype none
package agwh_pkg;

  localparam int KIND_W     = 1;
  localparam int AGE_W      = 16;
  localparam int WEIGHT_W   = 32;
  localparam int TOTAL_W    = 48;
  localparam int BIN_IDX_W  = 3;
  localparam int LIMIT_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Edge registers in the register map, whatever the parameter says
  localparam int NUM_EDGE_REGS = 6;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd1;
  localparam logic [AGE_W-1:0] EDGE_RESET [NUM_EDGE_REGS] =
    '{16'd10, 16'd20, 16'd30, 16'd40, 16'd50, 16'd60};

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_A = 3'd1;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_ADD  = 1'b0;
  localparam logic [KIND_W-1:0] KIND_READ = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

endpackage
`default_nettype wire

[design/agwh_if.sv]
`default_nettype none
interface agwh_in_if;
  import agwh_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [AGE_W-1:0]    age;
  logic                age_missing;
  logic [WEIGHT_W-1:0] weight;

  modport source (output valid, kind, age, age_missing, weight, input ready);
  modport sink   (input valid, kind, age, age_missing, weight, output ready);
endinterface

interface agwh_out_if;
  import agwh_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [BIN_IDX_W-1:0] bin_index;
  logic [TOTAL_W-1:0]   bin_total;
  logic                 last;

  modport source (output valid, bin_index, bin_total, last, input ready);
  modport sink   (input valid, bin_index, bin_total, last, output ready);
endinterface
`default_nettype wire

[design/agwh_ram.sv]
`default_nettype none
module agwh_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

[design/age_group_weighted_histogram.sv]
`default_nettype none
// Weighted histogram with programmable bin edges.
// in_req carries one request: an add (kind 0) puts its weight into the bin
// chosen by comparing age against the active edges in parallel, or into
// the missing bin when age_missing is set. A readout (kind 1) returns one
// result per bin on out_rsp, bins 0..n then the missing bin with last set,
// and clears every bin.
// Adds are taken one per cycle while no readout is running: the bin total is
// read from the RAM, added with saturation in the next cycle and written back,
// with the previous write forwarded when two adds hit the same bin.
// A readout streams its n+2 results at one per cycle while out_rsp does not
// stall, set by the single RAM read port; in_req.ready stays low until the last
// result has moved into the output register. The first result passes the read
// state, the RAM read register and the output register before it shows.
// A stall on out_rsp holds the output register and pauses the RAM reads.
// cfg_we writes limit_count (index 0) or edge_a..edge_f (1..6) at once;
// write them only while no request is in flight.
// rst_n (synchronous) restores the register reset values and marks all
// bins empty through per-bin valid bits, so no clearing pass is needed.
module age_group_weighted_histogram #(
  parameter int MAX_EDGES = 6
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  agwh_in_if.sink                             in_req,
  agwh_out_if.source                          out_rsp,
  input  wire logic                           cfg_we,
  input  wire logic [agwh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [agwh_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import agwh_pkg::*;

  localparam int NUM_SLOTS = MAX_EDGES + 2;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam logic [SLOT_W-1:0] MISSING_SLOT = SLOT_W'(MAX_EDGES + 1);

  // Configuration
  logic [LIMIT_W-1:0] limit_count_r;
  logic [AGE_W-1:0]   edge_r [NUM_EDGE_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_count_r <= LIMIT_RESET;
      for (int i = 0; i < NUM_EDGE_REGS; i++) begin
        edge_r[i] <= EDGE_RESET[i];
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_LIMIT) begin
        limit_count_r <= cfg_wdata[LIMIT_W-1:0];
      end
      for (int i = 0; i < NUM_EDGE_REGS; i++) begin
        if (cfg_index == REG_EDGE_A + CFG_IDX_W'(i)) begin
          edge_r[i] <= cfg_wdata[AGE_W-1:0];
        end
      end
    end
  end

  logic [LIMIT_W-1:0] n_eff;
  assign n_eff = (limit_count_r > LIMIT_W'(MAX_EDGES)) ? LIMIT_W'(MAX_EDGES)
                                                        : limit_count_r;

  // Bin selection
  logic [SLOT_W-1:0] age_slot;
  logic [SLOT_W-1:0] add_slot;

  always_comb begin
    age_slot = '0;
    for (int i = 0; i < NUM_EDGE_REGS; i++) begin
      if ((LIMIT_W'(i) < n_eff) && (edge_r[i] <= in_req.age)) begin
        age_slot = age_slot + SLOT_W'(1);
      end
    end
    add_slot = in_req.age_missing ? MISSING_SLOT : age_slot;
  end

  // Control
  state_t state_r, state_nxt;
  logic   in_ready;
  logic   rd_active;
  logic   in_acc;
  logic   add_issue;
  logic   rd_issue;
  logic   rd_last;
  logic   load_out;

  logic [SLOT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic              rd_done_r, rd_done_nxt;
  logic              pend_r, pend_nxt;
  logic [SLOT_W-1:0] pend_idx_r;
  logic              pend_last_r;
  logic              pend_hit_r;

  assign in_acc    = in_req.valid && in_ready;
  assign add_issue = in_acc && (in_req.kind == KIND_ADD);
  assign load_out  = pend_r && (!out_rsp.valid || out_rsp.ready);
  assign rd_issue  = rd_active && !rd_done_r && (!pend_r || load_out);
  assign rd_last   = (rd_cnt_r == SLOT_W'(n_eff) + SLOT_W'(1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_req.kind == KIND_READ)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_done_r && (!pend_r || load_out)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    rd_active = 1'b0;
    case (state_r)
      ST_IDLE: in_ready  = 1'b1;
      ST_READ: rd_active = 1'b1;
      default: in_ready  = 1'b0;
    endcase
  end

  assign in_req.ready = in_ready;

  always_comb begin
    rd_cnt_nxt  = rd_cnt_r;
    rd_done_nxt = rd_done_r;
    if (in_acc && (in_req.kind == KIND_READ)) begin
      rd_cnt_nxt  = '0;
      rd_done_nxt = 1'b0;
    end else if (rd_issue) begin
      rd_cnt_nxt  = rd_cnt_r + SLOT_W'(1);
      rd_done_nxt = rd_last;
    end
    pend_nxt = rd_issue ? 1'b1 : (load_out ? 1'b0 : pend_r);
  end

  // RAM access
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic [TOTAL_W-1:0] ram_rdata;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [TOTAL_W-1:0] ram_wdata;
  logic [SLOT_W-1:0] rd_addr;

  assign rd_addr   = rd_last ? MISSING_SLOT : rd_cnt_r;
  assign ram_re    = add_issue || rd_issue;
  assign ram_raddr = rd_issue ? rd_addr : add_slot;

  agwh_ram #(
    .WIDTH (TOTAL_W),
    .DEPTH (NUM_SLOTS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Bin valid bits: an empty bin reads as zero
  logic [NUM_SLOTS-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (rd_issue && rd_last) begin
      valid_r <= '0;
    end else if (ram_we) begin
      valid_r[ram_waddr] <= 1'b1;
    end
  end

  // Add update stage
  logic               s1_valid_r;
  logic [SLOT_W-1:0]  s1_slot_r;
  logic [WEIGHT_W-1:0] s1_weight_r;
  logic               s1_hit_r;
  logic               fw_valid_r;
  logic [SLOT_W-1:0]  fw_slot_r;
  logic [TOTAL_W-1:0] fw_data_r;
  logic [TOTAL_W-1:0] s1_base;
  logic [TOTAL_W:0]   s1_sum;

  always_comb begin
    if (fw_valid_r && (fw_slot_r == s1_slot_r)) begin
      s1_base = fw_data_r;
    end else if (s1_hit_r) begin
      s1_base = ram_rdata;
    end else begin
      s1_base = '0;
    end
    s1_sum = {1'b0, s1_base} + (TOTAL_W + 1)'(s1_weight_r);
  end

  assign ram_we    = s1_valid_r;
  assign ram_waddr = s1_slot_r;
  assign ram_wdata = s1_sum[TOTAL_W] ? TOTAL_MAX : s1_sum[TOTAL_W-1:0];

  always_ff @(posedge clk) begin
    s1_slot_r   <= add_slot;
    s1_weight_r <= in_req.weight;
    s1_hit_r    <= valid_r[add_slot];
    fw_slot_r   <= s1_slot_r;
    fw_data_r   <= ram_wdata;
  end

  // Readout and output register
  logic                 out_valid_r;
  logic [BIN_IDX_W-1:0] out_bin_index_r;
  logic [TOTAL_W-1:0]   out_bin_total_r;
  logic                 out_last_r;

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      pend_idx_r  <= rd_cnt_r;
      pend_last_r <= rd_last;
      pend_hit_r  <= valid_r[rd_addr];
    end
    if (load_out) begin
      out_bin_index_r <= BIN_IDX_W'(pend_idx_r);
      out_bin_total_r <= pend_hit_r ? ram_rdata : '0;
      out_last_r      <= pend_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_cnt_r    <= '0;
      rd_done_r   <= 1'b0;
      pend_r      <= 1'b0;
      s1_valid_r  <= 1'b0;
      fw_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_cnt_r   <= rd_cnt_nxt;
      rd_done_r  <= rd_done_nxt;
      pend_r     <= pend_nxt;
      s1_valid_r <= add_issue;
      fw_valid_r <= s1_valid_r;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.bin_index = out_bin_index_r;
  assign out_rsp.bin_total = out_bin_total_r;
  assign out_rsp.last      = out_last_r;

endmodule
`default_nettype wire

[verif/tb_age_group_weighted_histogram.sv]
module tb_age_group_weighted_histogram;
  import agwh_pkg::*;

  localparam int MAX_EDGES    = 6;
  localparam int NUM_SLOTS    = MAX_EDGES + 2;
  localparam int MISSING_SLOT = MAX_EDGES + 1;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 244;
  localparam int QUIET_FIRST  = 90;
  localparam int QUIET_LAST   = 150;
  localparam int HOLD_AT      = 200;

  typedef enum logic [1:0] {
    ROW_ADD,
    ROW_READ,
    ROW_REG
  } row_op_t;

  typedef struct {
    row_op_t               op;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [AGE_W-1:0]      age;
    logic                  miss;
    logic [WEIGHT_W-1:0]   weight;
    int                    reps;
    bit                    typed;
    logic [TOTAL_W-1:0]    t_first;
    logic [TOTAL_W-1:0]    t_miss;
  } plan_row_t;

  typedef struct packed {
    logic [BIN_IDX_W-1:0] bin_index;
    logic [TOTAL_W-1:0]   bin_total;
    logic                 last;
  } bin_rsp_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  agwh_in_if  req_if ();
  agwh_out_if rsp_if ();

  age_group_weighted_histogram #(
    .MAX_EDGES(MAX_EDGES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_if),
    .out_rsp  (rsp_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Histogram state as the block should hold it
  logic [LIMIT_W-1:0] limit_q;
  logic [AGE_W-1:0]   edge_q [NUM_EDGE_REGS];
  logic [TOTAL_W-1:0] bin_q [NUM_SLOTS];

  bin_rsp_t  pending_bins[$];
  plan_row_t plan_q[$];
  int        mismatches  = 0;
  int        idle_cycles = 0;
  bit        quiet       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int active_edges();
    if (limit_q > MAX_EDGES) return MAX_EDGES;
    return int'(limit_q);
  endfunction

  function automatic void write_model_reg(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] val);
    if (idx == REG_LIMIT) limit_q = val[LIMIT_W-1:0];
    else if (idx >= REG_EDGE_A && idx < REG_EDGE_A + NUM_EDGE_REGS)
      edge_q[idx - REG_EDGE_A] = val;
  endfunction

  function automatic void add_weight(logic [AGE_W-1:0] age, logic miss,
                                     logic [WEIGHT_W-1:0] w);
    int             slot;
    logic [TOTAL_W:0] sum;
    slot = 0;
    if (miss) slot = MISSING_SLOT;
    else
      for (int i = 0; i < active_edges(); i++)
        if (edge_q[i] <= age) slot++;
    sum = {1'b0, bin_q[slot]} + (TOTAL_W + 1)'(w);
    bin_q[slot] = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
  endfunction

  function automatic void read_out(bit typed, logic [TOTAL_W-1:0] t_first,
                                   logic [TOTAL_W-1:0] t_miss);
    int       n;
    bin_rsp_t r;
    n = active_edges();
    for (int i = 0; i <= n; i++) begin
      r.bin_index = BIN_IDX_W'(i);
      r.bin_total = (typed && i == 0) ? t_first : bin_q[i];
      r.last      = 1'b0;
      pending_bins.push_back(r);
    end
    r.bin_index = BIN_IDX_W'(n + 1);
    r.bin_total = typed ? t_miss : bin_q[MISSING_SLOT];
    r.last      = 1'b1;
    pending_bins.push_back(r);
    // clear every slot, also those beyond the current count
    for (int i = 0; i < NUM_SLOTS; i++) bin_q[i] = '0;
  endfunction

  function automatic void plan_add(logic [AGE_W-1:0] age, logic miss,
                                   logic [WEIGHT_W-1:0] w, int reps);
    plan_q.push_back('{op: ROW_ADD, reg_idx: '0, reg_val: '0, age: age, miss: miss,
                       weight: w, reps: reps, typed: 1'b0, t_first: '0, t_miss: '0});
  endfunction

  function automatic void plan_read(bit typed, logic [TOTAL_W-1:0] t_first,
                                    logic [TOTAL_W-1:0] t_miss);
    plan_q.push_back('{op: ROW_READ, reg_idx: '0, reg_val: '0, age: '0, miss: 1'b0,
                       weight: '0, reps: 1, typed: typed, t_first: t_first,
                       t_miss: t_miss});
  endfunction

  function automatic void plan_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    plan_q.push_back('{op: ROW_REG, reg_idx: idx, reg_val: val, age: '0, miss: 1'b0,
                       weight: '0, reps: 1, typed: 1'b0, t_first: '0, t_miss: '0});
  endfunction

  function automatic void flag_mismatch(string what, bin_rsp_t want, bin_rsp_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected bin %0d total %h last %b, got bin %0d total %h last %b",
               what, want.bin_index, want.bin_total, want.last,
               got.bin_index, got.bin_total, got.last);
  endfunction

  // Hold off until the block has nothing in flight
  task automatic quiesce();
    req_if.valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // cfg_we stays high; the caller drops it after the last write of a group
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    write_model_reg(idx, val);
  endtask

  task automatic send_req(logic [KIND_W-1:0] kind, logic [AGE_W-1:0] age, logic miss,
                          logic [WEIGHT_W-1:0] w, bit may_idle, bit typed,
                          logic [TOTAL_W-1:0] t_first, logic [TOTAL_W-1:0] t_miss);
    while (may_idle && !quiet && $urandom_range(99) < 29) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.kind        <= kind;
    req_if.age         <= age;
    req_if.age_missing <= miss;
    req_if.weight      <= w;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    if (kind == KIND_ADD) add_weight(age, miss, w);
    else read_out(typed, t_first, t_miss);
  endtask

  always @(posedge clk) begin
    if (!rst_n) rsp_if.ready <= 1'b0;
    else rsp_if.ready <= quiet || ($urandom_range(99) >= 29);
  end

  always @(posedge clk) begin : check_bins
    bin_rsp_t got;
    bin_rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got = {rsp_if.bin_index, rsp_if.bin_total, rsp_if.last};
      if (pending_bins.size() == 0) begin
        flag_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_bins.pop_front();
        if (got.bin_index !== want.bin_index || got.bin_total !== want.bin_total ||
            got.last !== want.last)
          flag_mismatch("bin mismatch", want, got);
      end
    end
  end

  // Count cycles without any accepted request or result
  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    plan_row_t             row;
    bit                    prev_reg;
    int                    sent;
    int                    phase;
    int                    burst;
    int                    base;
    logic [CFG_DATA_W-1:0] val;
    logic [KIND_W-1:0]     kind;
    logic [AGE_W-1:0]      age;
    logic                  miss;
    logic [WEIGHT_W-1:0]   w;

    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_wdata          <= '0;
    req_if.valid       <= 1'b0;
    req_if.kind        <= KIND_ADD;
    req_if.age         <= '0;
    req_if.age_missing <= 1'b0;
    req_if.weight      <= '0;

    limit_q = LIMIT_RESET;
    edge_q  = EDGE_RESET;
    for (int i = 0; i < NUM_SLOTS; i++) bin_q[i] = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset values, field extremes, edge equality,
    // zero and oversized edge counts, zero and duplicate edges
    plan_read(1'b1, '0, '0);
    plan_add(16'd0, 1'b0, 32'hFFFF_FFFF, 1);
    plan_add(16'hFFFF, 1'b0, 32'd1, 1);
    plan_add(16'hFFFF, 1'b1, 32'd0, 1);
    plan_add(16'd0, 1'b1, 32'h0000_0100, 1);
    plan_add(16'd9, 1'b0, 32'd5, 1);
    plan_add(16'd10, 1'b0, 32'd7, 1);
    plan_read(1'b1, 48'h1_0000_0004, 48'h100);
    plan_read(1'b1, '0, '0);
    plan_reg(REG_LIMIT, 16'd0);
    plan_add(16'd0, 1'b0, 32'd3, 1);
    plan_add(16'hFFFF, 1'b0, 32'd4, 1);
    plan_read(1'b1, 48'd7, '0);
    plan_reg(REG_LIMIT, 16'hFFFF);
    plan_reg(REG_EDGE_A, 16'd0);
    plan_reg(REG_EDGE_A + 3'd1, 16'd1);
    plan_reg(REG_EDGE_A + 3'd2, 16'h5555);
    plan_reg(REG_EDGE_A + 3'd3, 16'hAAAA);
    plan_reg(REG_EDGE_A + 3'd4, 16'hFFFF);
    plan_reg(REG_EDGE_A + 3'd5, 16'hFFFF);
    plan_reg(REG_NONE, 16'hFFFF);
    plan_add(16'd0, 1'b0, 32'd11, 1);
    plan_add(16'hFFFF, 1'b0, 32'd12, 1);
    plan_add(16'h5555, 1'b0, 32'd13, 1);
    plan_add(16'h1234, 1'b1, 32'h80, 1);
    plan_read(1'b0, '0, '0);

    prev_reg = 1'b0;
    foreach (plan_q[r]) begin
      row = plan_q[r];
      if (row.op == ROW_REG) begin
        if (!prev_reg) quiesce();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        if (prev_reg) cfg_we <= 1'b0;
        kind = (row.op == ROW_READ) ? KIND_READ : KIND_ADD;
        for (int rep = 0; rep < row.reps; rep++)
          send_req(kind, row.age, row.miss, row.weight, row.reps == 1, row.typed,
                   row.t_first, row.t_miss);
      end
      prev_reg = (row.op == ROW_REG);
    end
    if (prev_reg) cfg_we <= 1'b0;

    // Random phases, each under its own edge setting
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      quiesce();
      case (phase)
        0: val = 16'd6;
        1: val = 16'd1;
        2: val = 16'd0;
        3: val = 16'd7;
        default: val = CFG_DATA_W'($urandom);
      endcase
      write_reg(REG_LIMIT, val);
      case ($urandom_range(0, 3))
        0: begin
          base = $urandom_range(0, 50);
          for (int i = 0; i < NUM_EDGE_REGS; i++) begin
            base += $urandom_range(1, 40);
            write_reg(REG_EDGE_A + CFG_IDX_W'(i), CFG_DATA_W'(base));
          end
        end
        1: begin
          for (int i = 0; i < NUM_EDGE_REGS; i++)
            write_reg(REG_EDGE_A + CFG_IDX_W'(i), CFG_DATA_W'($urandom));
        end
        2: begin
          for (int i = 0; i < NUM_EDGE_REGS; i++) begin
            case ($urandom_range(0, 3))
              0: val = '0;
              1: val = '1;
              2: val = edge_q[$urandom_range(0, NUM_EDGE_REGS - 1)];
              default: val = CFG_DATA_W'($urandom);
            endcase
            write_reg(REG_EDGE_A + CFG_IDX_W'(i), val);
          end
        end
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, CFG_DATA_W'($urandom));
      cfg_we <= 1'b0;

      burst = $urandom_range(15, 40);
      for (int j = 0; j < burst && sent < RANDOM_ITEMS; j++) begin
        quiet = (sent >= QUIET_FIRST && sent < QUIET_LAST);
        if (sent == HOLD_AT) begin
          quiesce();
        end
        kind = ($urandom_range(99) < 12) ? KIND_READ : KIND_ADD;
        miss = ($urandom_range(99) < 15);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: age = edge_q[$urandom_range(0, NUM_EDGE_REGS - 1)]
                               + AGE_W'($urandom_range(0, 2)) - AGE_W'(1);
          5, 6, 7: age = AGE_W'($urandom);
          8: age = AGE_W'($urandom_range(0, 255));
          default: age = $urandom_range(0, 1) ? '1 : '0;
        endcase
        case ($urandom_range(0, 9))
          0: w = '0;
          1: w = '1;
          2, 3, 4, 5: w = $urandom;
          default: w = WEIGHT_W'($urandom_range(0, 4095));
        endcase
        send_req(kind, age, miss, w, 1'b1, 1'b0, '0, '0);
        sent++;
      end
      phase++;
    end
    quiet = 1'b0;

    req_if.valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_bins.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
